// File: hw/rtl/fatca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fatca_pkg
// Shared constants and types of the block chain allocator: table geometry,
// entry codes, operation and status codes, and the table access request.
// ----------------------------------------------------------------------------
package fatca_pkg;

  localparam int BLOCKS = 1024;
  localparam int ADDR_W = $clog2(BLOCKS);
  localparam int ENT_W  = ADDR_W + 1;
  localparam int CNT_W  = $clog2(BLOCKS + 1);

  localparam int BLK_W  = 10;
  localparam int FCNT_W = 11;

  // entry codes: top bit set marks a special entry, clear holds a link
  localparam logic [ENT_W-1:0] ENT_FREE = {1'b1, {ADDR_W{1'b0}}};
  localparam logic [ENT_W-1:0] ENT_END  = {1'b1, {(ADDR_W-1){1'b0}}, 1'b1};

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_FOLLOW = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [ENT_W-1:0]  wdata;
  } mem_req_t;

endpackage
`default_nettype wire

// File: hw/rtl/fatca_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fatca_table
// Link table storage: one port, write or read each cycle, registered read.
// ----------------------------------------------------------------------------
module fatca_table (
  input  wire logic                          clk,
  input  wire fatca_pkg::mem_req_t           req,
  output logic     [fatca_pkg::ENT_W-1:0]    rdata
);

  logic [fatca_pkg::ENT_W-1:0] mem [fatca_pkg::BLOCKS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/fat_block_chain_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fat_block_chain_allocator
// Allocation table sequencer: allocate lowest free block, release a chain,
// follow a link, all through one single-port link table.
// ----------------------------------------------------------------------------
// channel   dir  word fields (lsb up)
// s_axis    in   mode[1:0] block[11:2] link_after[12]
// m_axis    out  status[1:0] result_block[11:2] chain_end[12] freed_count[23:13]
//
// After reset a clearing pass writes every entry free; no input is taken.
// Allocate: with link_after the link target is read and checked first, then
// entries are read and checked from the lowest possibly free block up, with
// a final check when the table is full, and one or two writes follow. Free:
// each entry on the walk is read and checked, a stopping free entry included.
// Follow: one entry read and checked. Each item adds setup and result hand-off.
// One item is in work at a time; a finished word waits in the output register.
// ----------------------------------------------------------------------------
module fat_block_chain_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // mode, block, link_after
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata    // status, result_block, chain_end, freed_count
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_LNK_RD    = 4'd2;
  localparam logic [3:0] S_LNK_CHK   = 4'd3;
  localparam logic [3:0] S_SCAN_RD   = 4'd4;
  localparam logic [3:0] S_SCAN_CHK  = 4'd5;
  localparam logic [3:0] S_WR_END    = 4'd6;
  localparam logic [3:0] S_WR_LNK    = 4'd7;
  localparam logic [3:0] S_FREE_RD   = 4'd8;
  localparam logic [3:0] S_FREE_CHK  = 4'd9;
  localparam logic [3:0] S_FOLW_RD   = 4'd10;
  localparam logic [3:0] S_FOLW_CHK  = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  localparam logic [fatca_pkg::CNT_W-1:0] CNT_MAX = fatca_pkg::CNT_W'(fatca_pkg::BLOCKS);

  logic [3:0]                         state;
  logic [fatca_pkg::CNT_W-1:0]        cnt;
  logic [fatca_pkg::CNT_W-1:0]        hint;
  logic [fatca_pkg::CNT_W-1:0]        ptr;
  logic [fatca_pkg::ADDR_W-1:0]       op_blk;
  logic                               op_lnk;
  logic [1:0]                         res_status;
  logic [fatca_pkg::BLK_W-1:0]        res_block;
  logic                               res_end;
  logic [fatca_pkg::FCNT_W-1:0]       res_cnt;
  logic [fatca_pkg::ENT_W-1:0]        rdata;
  fatca_pkg::mem_req_t                req;

  logic [1:0]                         in_mode;
  logic [fatca_pkg::BLK_W-1:0]        in_block;
  logic                               in_lnk;
  logic                               in_range;
  logic                               rd_free;
  logic                               rd_end;
  logic [fatca_pkg::CNT_W-1:0]        cnt_inc;

  assign in_mode  = s_axis_tdata[1:0];
  assign in_block = s_axis_tdata[11:2];
  assign in_lnk   = s_axis_tdata[12];
  assign in_range = 32'(in_block) < 32'(fatca_pkg::BLOCKS);
  assign rd_free  = (rdata == fatca_pkg::ENT_FREE);
  assign rd_end   = (rdata == fatca_pkg::ENT_END);
  assign cnt_inc  = cnt + fatca_pkg::CNT_W'(1);

  assign s_axis_tready = (state == S_IDLE);

  fatca_table u_table (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  always_comb begin
    req.we    = 1'b0;
    req.addr  = ptr[fatca_pkg::ADDR_W-1:0];
    req.wdata = fatca_pkg::ENT_FREE;
    case (state)
      S_CLEAR: begin
        req.we   = 1'b1;
        req.addr = cnt[fatca_pkg::ADDR_W-1:0];
      end
      S_LNK_RD: req.addr = op_blk;
      S_WR_END: begin
        req.we    = 1'b1;
        req.wdata = fatca_pkg::ENT_END;
      end
      S_WR_LNK: begin
        req.we    = 1'b1;
        req.addr  = op_blk;
        req.wdata = {1'b0, ptr[fatca_pkg::ADDR_W-1:0]};
      end
      S_FREE_CHK: req.we = !rd_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cnt           <= '0;
      hint          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt_inc;
          if (cnt_inc == CNT_MAX) begin
            state <= S_IDLE;
            hint  <= '0;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_blk     <= fatca_pkg::ADDR_W'(in_block);
            op_lnk     <= in_lnk;
            ptr        <= fatca_pkg::CNT_W'(in_block);
            cnt        <= '0;
            res_status <= fatca_pkg::ST_BAD;
            res_block  <= '0;
            res_end    <= 1'b0;
            res_cnt    <= '0;
            state      <= S_DONE;
            case (in_mode)
              fatca_pkg::OP_ALLOC: begin
                if (!in_lnk) begin
                  ptr   <= hint;
                  state <= S_SCAN_RD;
                end else if (in_range) begin
                  state <= S_LNK_RD;
                end
              end
              fatca_pkg::OP_FREE:   if (in_range) state <= S_FREE_RD;
              fatca_pkg::OP_FOLLOW: if (in_range) state <= S_FOLW_RD;
              default: ;
            endcase
          end
        end
        S_LNK_RD: state <= S_LNK_CHK;
        S_LNK_CHK: begin
          if (rd_free) begin
            state <= S_DONE;
          end else begin
            ptr   <= hint;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (ptr == CNT_MAX) begin
            res_status <= fatca_pkg::ST_FULL;
            hint       <= ptr;
            state      <= S_DONE;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (rd_free) begin
            state <= S_WR_END;
          end else begin
            ptr   <= ptr + fatca_pkg::CNT_W'(1);
            state <= S_SCAN_RD;
          end
        end
        S_WR_END: begin
          hint       <= ptr + fatca_pkg::CNT_W'(1);
          res_status <= fatca_pkg::ST_OK;
          res_block  <= fatca_pkg::BLK_W'(ptr);
          state      <= op_lnk ? S_WR_LNK : S_DONE;
        end
        S_WR_LNK: state <= S_DONE;
        S_FREE_RD: state <= S_FREE_CHK;
        S_FREE_CHK: begin
          if (rd_free) begin
            if (cnt != '0) begin
              res_status <= fatca_pkg::ST_OK;
              res_cnt    <= fatca_pkg::FCNT_W'(cnt);
            end
            state <= S_DONE;
          end else begin
            cnt <= cnt_inc;
            if (ptr < hint) begin
              hint <= ptr;
            end
            if (rd_end || cnt_inc == CNT_MAX) begin
              res_status <= fatca_pkg::ST_OK;
              res_cnt    <= fatca_pkg::FCNT_W'(cnt_inc);
              state      <= S_DONE;
            end else begin
              ptr   <= fatca_pkg::CNT_W'(rdata[fatca_pkg::ADDR_W-1:0]);
              state <= S_FREE_RD;
            end
          end
        end
        S_FOLW_RD: state <= S_FOLW_CHK;
        S_FOLW_CHK: begin
          if (!rd_free) begin
            res_status <= fatca_pkg::ST_OK;
            if (rd_end) begin
              res_end <= 1'b1;
            end else begin
              res_block <= fatca_pkg::BLK_W'(rdata[fatca_pkg::ADDR_W-1:0]);
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {res_cnt, res_end, res_block, res_status};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on back-to-back cycles");

  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    hint <= CNT_MAX)
    else $error("free search hint beyond table");

  a_done_drives_out: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
    else $error("result not presented");

  a_clear_blocks_input: assert property (@(posedge clk)
    state == S_CLEAR |-> !s_axis_tready)
    else $error("input taken during clearing pass");
`endif

endmodule
`default_nettype wire

// File: verif/fat_block_chain_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat_block_chain_allocator_tb
// Streams allocate, free-chain, follow and unknown commands into the block
// chain allocator and checks every reply word against a shadow allocation
// table kept in the bench. Corner cases come first, then random chain
// building, walking and release, one fill of the whole table up to disk
// full, and a long output stall, under three patterns of bus idling.
// ----------------------------------------------------------------------------
module fat_block_chain_allocator_tb;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int PHASE_ITEMS = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 2200;

  typedef struct packed {
    logic                        link_after;
    logic [fatca_pkg::BLK_W-1:0] blk;
    logic [1:0]                  mode;
  } fat_cmd_t;

  typedef struct packed {
    logic [fatca_pkg::FCNT_W-1:0] freed_count;
    logic                         chain_end;
    logic [fatca_pkg::BLK_W-1:0]  result_block;
    logic [1:0]                   status;
  } fat_reply_t;

  typedef logic [fatca_pkg::BLOCKS-1:0][fatca_pkg::ENT_W-1:0] fat_tbl_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // mode, block, link_after
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // status, result_block, chain_end, freed_count

  fat_tbl_t   plan_tbl;
  fat_tbl_t   live_tbl;
  fat_cmd_t   cmd_backlog[$];
  fat_reply_t expected_replies[$];

  int issued_cnt = 0;
  int taken_cnt = 0;
  int got_total = 0;
  int err_cnt = 0;
  int phase_id = 0;
  int hold_mark = 32'h7fff_ffff;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int s_calm = 0;
  int r_calm = 0;
  bit in_acc = 1'b0;

  fat_block_chain_allocator DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic fat_reply_t fat_execute(inout fat_tbl_t tbl, input fat_cmd_t cmd);
    fat_reply_t                   rep;
    logic [fatca_pkg::ENT_W-1:0]  nxt;
    logic [fatca_pkg::ADDR_W-1:0] cur;
    int                           idx;
    int                           cnt;
    bit                           done;
    rep = '0;
    case (cmd.mode)
      fatca_pkg::OP_ALLOC: begin
        if (cmd.link_after && tbl[cmd.blk] == fatca_pkg::ENT_FREE) begin
          rep.status = fatca_pkg::ST_BAD;
        end else begin
          idx = -1;
          for (int i = 0; i < fatca_pkg::BLOCKS; i++) begin
            if (idx < 0 && tbl[i] == fatca_pkg::ENT_FREE) idx = i;
          end
          if (idx < 0) begin
            rep.status = fatca_pkg::ST_FULL;
          end else begin
            tbl[idx] = fatca_pkg::ENT_END;
            if (cmd.link_after) tbl[cmd.blk] = {1'b0, fatca_pkg::ADDR_W'(idx)};
            rep.result_block = fatca_pkg::BLK_W'(idx);
          end
        end
      end
      fatca_pkg::OP_FREE: begin
        if (tbl[cmd.blk] == fatca_pkg::ENT_FREE) begin
          rep.status = fatca_pkg::ST_BAD;
        end else begin
          cur = cmd.blk;
          cnt = 0;
          done = 1'b0;
          for (int n = 0; n < fatca_pkg::BLOCKS && !done; n++) begin
            if (tbl[cur] == fatca_pkg::ENT_FREE) begin
              done = 1'b1;
            end else begin
              nxt = tbl[cur];
              tbl[cur] = fatca_pkg::ENT_FREE;
              cnt++;
              if (nxt[fatca_pkg::ADDR_W]) done = 1'b1;
              else cur = nxt[fatca_pkg::ADDR_W-1:0];
            end
          end
          rep.freed_count = fatca_pkg::FCNT_W'(cnt);
        end
      end
      fatca_pkg::OP_FOLLOW: begin
        if (tbl[cmd.blk] == fatca_pkg::ENT_FREE) begin
          rep.status = fatca_pkg::ST_BAD;
        end else if (tbl[cmd.blk] == fatca_pkg::ENT_END) begin
          rep.chain_end = 1'b1;
        end else begin
          rep.result_block = tbl[cmd.blk][fatca_pkg::ADDR_W-1:0];
        end
      end
      default: begin
        rep.status = fatca_pkg::ST_BAD;
      end
    endcase
    return rep;
  endfunction

  function automatic int pick_used();
    int start;
    start = $urandom_range(fatca_pkg::BLOCKS - 1);
    for (int k = 0; k < fatca_pkg::BLOCKS; k++) begin
      if (plan_tbl[(start + k) % fatca_pkg::BLOCKS] != fatca_pkg::ENT_FREE) begin
        return (start + k) % fatca_pkg::BLOCKS;
      end
    end
    return -1;
  endfunction

  function automatic int used_count();
    int n;
    n = 0;
    for (int i = 0; i < fatca_pkg::BLOCKS; i++) begin
      if (plan_tbl[i] != fatca_pkg::ENT_FREE) n++;
    end
    return n;
  endfunction

  function automatic bit idle_now(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic issue(input logic [1:0] mode, input int blk, input logic lnk,
                       output fat_reply_t rep);
    fat_cmd_t c;
    c.mode = mode;
    c.blk = fatca_pkg::BLK_W'(blk);
    c.link_after = lnk;
    rep = fat_execute(plan_tbl, c);
    cmd_backlog.push_back(c);
    issued_cnt++;
  endtask

  task automatic walk_corner_cases();
    fat_reply_t rep;
    issue(fatca_pkg::OP_FOLLOW, 0, 1'b0, rep);
    issue(fatca_pkg::OP_FREE, 0, 1'b0, rep);
    issue(fatca_pkg::OP_ALLOC, 5, 1'b1, rep);
    issue(OP_UNKNOWN, fatca_pkg::BLOCKS - 1, 1'b1, rep);
    issue(fatca_pkg::OP_ALLOC, 0, 1'b0, rep);
    issue(fatca_pkg::OP_ALLOC, 0, 1'b1, rep);
    issue(fatca_pkg::OP_ALLOC, 1, 1'b1, rep);
    issue(fatca_pkg::OP_FOLLOW, 0, 1'b1, rep);
    issue(fatca_pkg::OP_FOLLOW, 2, 1'b0, rep);
    // relink 0 to a newly allocated block, dropping its old successor
    issue(fatca_pkg::OP_ALLOC, 0, 1'b1, rep);
    issue(fatca_pkg::OP_FOLLOW, 0, 1'b0, rep);
    issue(fatca_pkg::OP_FREE, 3, 1'b0, rep);
    // walk stops at the block just released
    issue(fatca_pkg::OP_FREE, 0, 1'b1, rep);
    issue(fatca_pkg::OP_FOLLOW, 1, 1'b0, rep);
    issue(fatca_pkg::OP_FREE, 1, 1'b0, rep);
    issue(OP_UNKNOWN, 0, 1'b0, rep);
    issue(fatca_pkg::OP_ALLOC, fatca_pkg::BLOCKS - 1, 1'b0, rep);
    issue(fatca_pkg::OP_FOLLOW, fatca_pkg::BLOCKS - 1, 1'b1, rep);
    issue(fatca_pkg::OP_FREE, fatca_pkg::BLOCKS - 1, 1'b0, rep);
    issue(fatca_pkg::OP_FREE, 0, 1'b0, rep);
  endtask

  task automatic random_mix(input int n);
    fat_reply_t rep;
    int target;
    int b;
    int len;
    int steps;
    target = issued_cnt + n;
    while (issued_cnt < target) begin
      b = pick_used();
      case ($urandom_range(9))
        0, 1, 2: begin
          if (used_count() > 160) begin
            issue(fatca_pkg::OP_FREE, b, 1'b0, rep);
          end else begin
            issue(fatca_pkg::OP_ALLOC, $urandom_range(fatca_pkg::BLOCKS - 1), 1'b0, rep);
            len = ($urandom_range(7) == 0) ? $urandom_range(30, 8) : $urandom_range(5, 1);
            while (len > 0 && rep.status == fatca_pkg::ST_OK) begin
              issue(fatca_pkg::OP_ALLOC, int'(rep.result_block), 1'b1, rep);
              len--;
            end
          end
        end
        3: begin
          steps = 0;
          if (b < 0) b = $urandom_range(fatca_pkg::BLOCKS - 1);
          do begin
            issue(fatca_pkg::OP_FOLLOW, b, 1'($urandom_range(1)), rep);
            b = int'(rep.result_block);
            steps++;
          end while (rep.status == fatca_pkg::ST_OK && !rep.chain_end && steps < 64);
        end
        4, 5: begin
          if (b < 0) b = $urandom_range(fatca_pkg::BLOCKS - 1);
          issue(fatca_pkg::OP_FREE, b, 1'($urandom_range(1)), rep);
        end
        6: begin
          if (b >= 0 && $urandom_range(3) != 0) begin
            issue(fatca_pkg::OP_ALLOC, b, 1'b1, rep);
          end else begin
            issue(fatca_pkg::OP_ALLOC, $urandom_range(fatca_pkg::BLOCKS - 1),
                  1'($urandom_range(1)), rep);
          end
        end
        7: begin
          if (b < 0 || $urandom_range(1)) b = $urandom_range(fatca_pkg::BLOCKS - 1);
          issue(fatca_pkg::OP_FOLLOW, b, 1'($urandom_range(1)), rep);
        end
        8: begin
          issue(OP_UNKNOWN, $urandom_range(fatca_pkg::BLOCKS - 1), 1'($urandom_range(1)), rep);
        end
        default: begin
          if ($urandom_range(1)) begin
            issue(fatca_pkg::OP_FREE, $urandom_range(fatca_pkg::BLOCKS - 1), 1'b0, rep);
          end else begin
            issue(fatca_pkg::OP_FOLLOW, $urandom_range(fatca_pkg::BLOCKS - 1), 1'b1, rep);
          end
        end
      endcase
    end
  endtask

  task automatic fill_and_release();
    fat_reply_t rep;
    int prev;
    int tgt;
    prev = -1;
    rep = '0;
    while (rep.status != fatca_pkg::ST_FULL) begin
      tgt = pick_used();
      if (prev >= 0 && $urandom_range(9) < 8) begin
        issue(fatca_pkg::OP_ALLOC, prev, 1'b1, rep);
      end else if (tgt >= 0 && $urandom_range(1)) begin
        issue(fatca_pkg::OP_ALLOC, tgt, 1'b1, rep);
      end else begin
        issue(fatca_pkg::OP_ALLOC, $urandom_range(fatca_pkg::BLOCKS - 1), 1'b0, rep);
      end
      prev = (rep.status == fatca_pkg::ST_OK) ? int'(rep.result_block) : -1;
    end
    issue(fatca_pkg::OP_ALLOC, fatca_pkg::BLOCKS - 1, 1'b1, rep);
    issue(fatca_pkg::OP_ALLOC, 0, 1'b0, rep);
    issue(fatca_pkg::OP_FOLLOW, fatca_pkg::BLOCKS - 1, 1'b0, rep);
    issue(fatca_pkg::OP_FOLLOW, fatca_pkg::BLOCKS / 2, 1'b1, rep);
    issue(fatca_pkg::OP_FREE, fatca_pkg::BLOCKS - 1, 1'b0, rep);
    issue(fatca_pkg::OP_ALLOC, 0, 1'b0, rep);
    while (used_count() > 48) begin
      issue(fatca_pkg::OP_FREE, pick_used(), 1'($urandom_range(1)), rep);
    end
  endtask

  task automatic drain();
    while (taken_cnt != issued_cnt || expected_replies.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ERROR %s: expected %0d, actual %0d", $time, what, want, got);
      err_cnt++;
    end
  endtask

  always @(negedge clk) begin
    if (s_calm != 0) s_calm <= s_calm - 1;
    else if ($urandom_range(199) == 0) s_calm <= $urandom_range(80, 20);
    if (!s_axis_tvalid || in_acc) begin
      if (cmd_backlog.size() != 0 &&
          (s_calm != 0 || !idle_now((phase_id == 0) ? 13 : (phase_id == 1) ? 88 : 0))) begin
        s_axis_tdata <= {3'b000, cmd_backlog.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && got_total >= hold_mark) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (r_calm != 0) r_calm <= r_calm - 1;
    else if ($urandom_range(199) == 0) r_calm <= $urandom_range(80, 20);
    m_axis_tready <= (hold_left == 0) &&
      (r_calm != 0 || !idle_now((phase_id == 0) ? 88 : (phase_id == 1) ? 13 : 0));
  end

  always @(posedge clk) begin
    fat_reply_t got;
    fat_reply_t want;
    if (rst) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        got_total <= got_total + 1;
        if (expected_replies.size() == 0) begin
          $display("%0t ERROR unexpected word: expected none, actual %h", $time,
                   m_axis_tdata);
          err_cnt++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 16'(want.status), 16'(got.status));
          check_field("result_block", 16'(want.result_block), 16'(got.result_block));
          check_field("chain_end", 16'(want.chain_end), 16'(got.chain_end));
          check_field("freed_count", 16'(want.freed_count), 16'(got.freed_count));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(fat_execute(live_tbl, fat_cmd_t'(s_axis_tdata[12:0])));
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  initial begin
    plan_tbl = {fatca_pkg::BLOCKS{fatca_pkg::ENT_FREE}};
    live_tbl = {fatca_pkg::BLOCKS{fatca_pkg::ENT_FREE}};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);
    phase_id = 0;
    walk_corner_cases();
    random_mix(PHASE_ITEMS);
    drain();
    @(posedge clk);
    phase_id = 1;
    random_mix(PHASE_ITEMS);
    drain();
    @(posedge clk);
    phase_id = 2;
    hold_mark = got_total + 10;
    random_mix(PHASE_ITEMS / 2);
    fill_and_release();
    random_mix(PHASE_ITEMS / 2);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("fat_block_chain_allocator: match");
    end else begin
      $display("fat_block_chain_allocator: mismatch");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("fat_block_chain_allocator: mismatch");
    $finish;
  end

endmodule
